>>> hw/rtl/edge_dedup_hash_set_macros.svh
// Assertion macros for the edge dedup hash set RTL.
`ifndef EDGE_DEDUP_HASH_SET_MACROS_SVH
`define EDGE_DEDUP_HASH_SET_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define EDH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edh assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define EDH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edh assertion failed");

`endif

>>> hw/rtl/edh_pkg.sv
// Package: constants, widths and controller/datapath interface types.
`default_nettype none
package edh_pkg;

	localparam int TABLE_SLOTS = 2048;
	localparam int MAX_PROBES  = 32;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int PROBE_W     = $clog2(MAX_PROBES + 1);
	localparam int SLOT_IDX_W  = 11;
	localparam int COORD_W     = 15;
	localparam int HASH_W      = 32;

	localparam logic [HASH_W-1:0] HASH_MX  = 32'd73856093;
	localparam logic [HASH_W-1:0] HASH_MY  = 32'd19349663;
	localparam logic [HASH_W-1:0] HASH_MZ  = 32'd83492791;
	localparam logic [HASH_W-1:0] HASH_MIX = 32'd2654435761;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input beat
		logic hash1;    // coordinate products
		logic hash2;    // endpoint hashes, ordering
		logic hash3;    // key mix, home slot
		logic probe;    // evaluate probe, advance or finish
		logic clr;      // write zero at sweep address
		logic clr_res;  // result of a clear operation
		logic emit;     // load output register
	} edh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic probe_end;
	} edh_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/edh_ifs.sv
// Valid/ready channel interfaces for edge beats and result beats.
`default_nettype none
interface edh_edge_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [14:0]       a_x;
	logic signed [14:0]       a_y;
	logic signed [14:0]       a_z;
	logic signed [14:0]       b_x;
	logic signed [14:0]       b_y;
	logic signed [14:0]       b_z;

	modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface edh_result_if;
	logic        valid;
	logic        ready;
	logic        draw;
	logic        stored;
	logic [10:0] slot_index;

	modport source (output valid, draw, stored, slot_index, input ready);
	modport sink (input valid, draw, stored, slot_index, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/edh_ctrl.sv
// Controller: one-hot sequencer for hashing, probing, clearing and result hand-off.
`default_nettype none
`include "edge_dedup_hash_set_macros.svh"
module edh_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_opcode,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output edh_pkg::edh_cmd_t    cmd,
	input  wire edh_pkg::edh_sts_t sts
);
	import edh_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_HASH1 = 8'b0000_0100,
		S_HASH2 = 8'b0000_1000,
		S_HASH3 = 8'b0001_0000,
		S_FIRST = 8'b0010_0000,
		S_PROBE = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   clr_emit_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					cmd.clr_res = clr_emit_q;
					state_d     = clr_emit_q ? S_EMIT : S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_opcode == OP_CLEAR) ? S_CLEAR : S_HASH1;
				end
			end
			S_HASH1: begin
				cmd.hash1 = 1'b1;
				state_d   = S_HASH2;
			end
			S_HASH2: begin
				cmd.hash2 = 1'b1;
				state_d   = S_HASH3;
			end
			S_HASH3: begin
				cmd.hash3 = 1'b1;
				state_d   = S_FIRST;
			end
			S_FIRST: begin
				state_d = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.probe_end) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_emit_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready && in_opcode == OP_CLEAR) begin
				clr_emit_q <= 1'b1;
			end else if (state_q == S_CLEAR && sts.clr_done) begin
				clr_emit_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`EDH_ASSERT_NOW(a_emit_into_free, cmd.emit, out_free)
	`EDH_ASSERT_NEXT(a_probe_to_emit, state_q == S_PROBE && sts.probe_end, state_q == S_EMIT)
	`EDH_ASSERT_NOW(a_no_accept_clearing, state_q == S_CLEAR, !in_ready)
	`EDH_ASSERT_NOW(a_valid_from_emit, $rose(out_valid_q), $past(state_q == S_EMIT))

endmodule
`default_nettype wire

>>> hw/rtl/edh_dp.sv
// Datapath: endpoint hashing, key mixing, probe walk and the key table memory.
`default_nettype none
module edh_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire edh_pkg::edh_cmd_t     cmd,
	output edh_pkg::edh_sts_t          sts,
	input  wire logic signed [14:0]    a_x,
	input  wire logic signed [14:0]    a_y,
	input  wire logic signed [14:0]    a_z,
	input  wire logic signed [14:0]    b_x,
	input  wire logic signed [14:0]    b_y,
	input  wire logic signed [14:0]    b_z,
	output logic                       draw,
	output logic                       stored,
	output logic [10:0]                slot_index
);
	import edh_pkg::*;

	localparam int EXT_W = HASH_W - COORD_W;

	// captured beat
	logic [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	// products, hashes, key
	logic [HASH_W-1:0] pax_q, pay_q, paz_q, pbx_q, pby_q, pbz_q;
	logic [HASH_W-1:0] lo_q, hi_q, key_q;
	logic [HASH_W-1:0] ha, hb, mix, key_d;
	// probe walk
	logic [SLOT_W-1:0]  slot_q, slot_nxt, rd_addr, wr_addr, clr_addr_q;
	logic [PROBE_W-1:0] probe_q;
	logic [HASH_W-1:0]  rd_q, wr_data;
	logic               wr_en, hit, empty, last;
	// result
	logic                  res_draw_q, res_stored_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  out_draw_q, out_stored_q;
	logic [SLOT_IDX_W-1:0] out_slot_q;

	logic [HASH_W-1:0] key_mem [TABLE_SLOTS];

	function automatic logic [HASH_W-1:0] sext(input logic [COORD_W-1:0] v);
		return {{EXT_W{v[COORD_W-1]}}, v};
	endfunction

	function automatic logic [HASH_W-1:0] nz(input logic [HASH_W-1:0] v);
		return (v == '0) ? HASH_W'(1) : v;
	endfunction

	assign ha    = nz(pax_q ^ pay_q ^ paz_q);
	assign hb    = nz(pbx_q ^ pby_q ^ pbz_q);
	assign mix   = lo_q * HASH_MIX;
	assign key_d = nz(mix ^ hi_q);

	// rd_q holds the entry at slot_q while probing
	assign hit   = rd_q == key_q;
	assign empty = rd_q == '0;
	assign last  = probe_q == PROBE_W'(MAX_PROBES - 1);

	assign sts.probe_end = hit || empty || last;
	assign sts.clr_done  = clr_addr_q == SLOT_W'(TABLE_SLOTS - 1);

	assign slot_nxt = slot_q + 1'b1;
	assign rd_addr  = cmd.probe ? slot_nxt : slot_q;
	assign wr_en    = cmd.clr || (cmd.probe && empty);
	assign wr_addr  = cmd.clr ? clr_addr_q : slot_q;
	assign wr_data  = cmd.clr ? '0 : key_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data;
		end
		rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= a_x;
			ay_q <= a_y;
			az_q <= a_z;
			bx_q <= b_x;
			by_q <= b_y;
			bz_q <= b_z;
		end
		if (cmd.hash1) begin
			pax_q <= sext(ax_q) * HASH_MX;
			pay_q <= sext(ay_q) * HASH_MY;
			paz_q <= sext(az_q) * HASH_MZ;
			pbx_q <= sext(bx_q) * HASH_MX;
			pby_q <= sext(by_q) * HASH_MY;
			pbz_q <= sext(bz_q) * HASH_MZ;
		end
		if (cmd.hash2) begin
			lo_q <= (ha < hb) ? ha : hb;
			hi_q <= (ha < hb) ? hb : ha;
		end
		if (cmd.hash3) begin
			key_q   <= key_d;
			slot_q  <= key_d[SLOT_W-1:0];
			probe_q <= '0;
		end
		if (cmd.probe) begin
			if (sts.probe_end) begin
				res_draw_q   <= !hit;
				res_stored_q <= empty;
				res_slot_q   <= slot_q;
			end else begin
				slot_q  <= slot_nxt;
				probe_q <= probe_q + 1'b1;
			end
		end
		if (cmd.clr_res) begin
			res_draw_q   <= 1'b0;
			res_stored_q <= 1'b0;
			res_slot_q   <= '0;
		end
		if (cmd.emit) begin
			out_draw_q   <= res_draw_q;
			out_stored_q <= res_stored_q;
			out_slot_q   <= SLOT_IDX_W'(res_slot_q);
		end
	end

	assign draw       = out_draw_q;
	assign stored     = out_stored_q;
	assign slot_index = out_slot_q;

endmodule
`default_nettype wire

>>> hw/rtl/edge_dedup_hash_set.sv
// Edge dedup hash set: decides whether a mesh edge is drawn for the first time.
// Usage notes:
//  - edge_ch takes one beat per edge: opcode 0 inserts the edge (a_*, b_* are
//    signed endpoint coordinates scaled by 8192), opcode 1 empties the table.
//  - result_ch returns exactly one beat per edge_ch beat, in order: draw, stored
//    and the slot that holds the key (or the last slot probed).
//  - Insert: the edge is hashed in turn (products, endpoint hashes, key mix),
//    then comes the first table read, then one probe per cycle through the
//    single-read-port key memory with its registered output; 1 to 32 table
//    slots are probed.
//  - Clear: the 2048-entry sweep writes one zero per cycle through the memory
//    write port.
//  - One edge is in flight at a time; edge_ch.ready is high only while idle.
//  - After arst_n releases, a clearing pass empties the table; no beat is
//    accepted and no result is produced during it.
//  - result_ch has an output register: a new edge is accepted while a finished
//    result waits; if the receiver still stalls when the next result is ready,
//    the block holds it and stops taking beats until result_ch.ready rises.
`default_nettype none
module edge_dedup_hash_set (
	input  wire logic    clk,
	input  wire logic    arst_n,
	edh_edge_if.sink     edge_ch,
	edh_result_if.source result_ch
);
	import edh_pkg::*;

	edh_cmd_t cmd;
	edh_sts_t sts;

	// sequencer: owns handshakes and the output-valid flag
	edh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (edge_ch.valid),
		.in_opcode (edge_ch.opcode),
		.in_ready  (edge_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// hashing, probe walk, key table and result payload
	edh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.a_x        (edge_ch.a_x),
		.a_y        (edge_ch.a_y),
		.a_z        (edge_ch.a_z),
		.b_x        (edge_ch.b_x),
		.b_y        (edge_ch.b_y),
		.b_z        (edge_ch.b_z),
		.draw       (result_ch.draw),
		.stored     (result_ch.stored),
		.slot_index (result_ch.slot_index)
	);

endmodule
`default_nettype wire
